@@ src/gemm_pkg.sv @@
// Shared types, constants and helpers for the general matrix multiply block.
// Used by the channel interfaces, the register file, the controller and the datapath.
package gemm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int DATA_W    = 32;
   localparam int ACC_W     = 48;
   localparam int MUL_W     = DATA_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int FRAC_W    = 16;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_LOAD_C = 2'd2,
      CMD_START  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_TRANS_A = 3'd0,
      CSR_TRANS_B = 3'd1,
      CSR_ROWS_M  = 3'd2,
      CSR_COLS_N  = 3'd3,
      CSR_INNER_K = 3'd4,
      CSR_ALPHA   = 3'd5,
      CSR_BETA    = 3'd6,
      CSR_SPARE   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_HI,
      ST_LO,
      ST_CMUL,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_AB,
      MUL_ALPHA_HI,
      MUL_ALPHA_LO,
      MUL_BETA_C
   } mul_sel_type;

   typedef struct packed {
      logic                     trans_a;
      logic                     trans_b;
      logic [DIM_W-1:0]         rows_m;
      logic [DIM_W-1:0]         cols_n;
      logic [DIM_W-1:0]         inner_k;
      logic signed [DATA_W-1:0] alpha_scale;
      logic signed [DATA_W-1:0] beta_scale;
   } cfg_type;

   typedef struct packed {
      logic              ld_a;
      logic              ld_b;
      logic              ld_c;
      logic              clr_acc;
      logic              acc_en;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              res_load;
      logic              res_add;
      logic              out_load;
      logic              wb_en;
      logic [ADDR_W-1:0] a_addr;
      logic [ADDR_W-1:0] b_addr;
      logic [ADDR_W-1:0] c_addr;
   } ctrl_cmd_type;

   // Linear store address of element [row][col] as stored.
   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
      logic [2*IDX_W:0] lin;
      lin = (2*IDX_W+1)'(row) * (2*IDX_W+1)'(MAX_DIM) + (2*IDX_W+1)'(col);
      return lin[ADDR_W-1:0];
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim);
      return (dim > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim;
   endfunction

endpackage

@@ src/gemm_if.sv @@
// Valid/ready channel interfaces for command beats in and result beats out.
// Depends on gemm_pkg for field widths.
interface gemm_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         command;
   logic [gemm_pkg::IDX_W-1:0]         row;
   logic [gemm_pkg::IDX_W-1:0]         col;
   logic signed [gemm_pkg::DATA_W-1:0] value;

   modport source (output valid, command, row, col, value, input ready);
   modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface gemm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [gemm_pkg::IDX_W-1:0]         out_row;
   logic [gemm_pkg::IDX_W-1:0]         out_col;
   logic signed [gemm_pkg::DATA_W-1:0] out_value;
   logic                               last;

   modport source (output valid, out_row, out_col, out_value, last, input ready);
   modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

@@ src/gemm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module gemm_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/gemm_csr.sv @@
// Configuration register file behind the APB-style port.
// Depends on gemm_pkg for the register index codes and the config struct.
module gemm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gemm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output gemm_pkg::cfg_type               cfg
);

   gemm_pkg::cfg_type       cfg_ff, cfg_in;
   gemm_pkg::csr_index_type index;
   logic                    wr_en;

   assign index = gemm_pkg::csr_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            gemm_pkg::CSR_TRANS_A: cfg_in.trans_a     = csr_pwdata[0];
            gemm_pkg::CSR_TRANS_B: cfg_in.trans_b     = csr_pwdata[0];
            gemm_pkg::CSR_ROWS_M:  cfg_in.rows_m      = csr_pwdata[gemm_pkg::DIM_W-1:0];
            gemm_pkg::CSR_COLS_N:  cfg_in.cols_n      = csr_pwdata[gemm_pkg::DIM_W-1:0];
            gemm_pkg::CSR_INNER_K: cfg_in.inner_k     = csr_pwdata[gemm_pkg::DIM_W-1:0];
            gemm_pkg::CSR_ALPHA:   cfg_in.alpha_scale = csr_pwdata;
            gemm_pkg::CSR_BETA:    cfg_in.beta_scale  = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trans_a     <= 1'b0;
         cfg_ff.trans_b     <= 1'b0;
         cfg_ff.rows_m      <= gemm_pkg::DIM_W'(gemm_pkg::MAX_DIM);
         cfg_ff.cols_n      <= gemm_pkg::DIM_W'(gemm_pkg::MAX_DIM);
         cfg_ff.inner_k     <= gemm_pkg::DIM_W'(gemm_pkg::MAX_DIM);
         cfg_ff.alpha_scale <= 32'sd65536;
         cfg_ff.beta_scale  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         gemm_pkg::CSR_TRANS_A: csr_prdata = {31'd0, cfg_ff.trans_a};
         gemm_pkg::CSR_TRANS_B: csr_prdata = {31'd0, cfg_ff.trans_b};
         gemm_pkg::CSR_ROWS_M:  csr_prdata = 32'(cfg_ff.rows_m);
         gemm_pkg::CSR_COLS_N:  csr_prdata = 32'(cfg_ff.cols_n);
         gemm_pkg::CSR_INNER_K: csr_prdata = 32'(cfg_ff.inner_k);
         gemm_pkg::CSR_ALPHA:   csr_prdata = cfg_ff.alpha_scale;
         gemm_pkg::CSR_BETA:    csr_prdata = cfg_ff.beta_scale;
         default:               csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

@@ src/gemm_ctrl.sv @@
// Sequencer: walks columns, rows and the inner dimension and issues datapath commands.
// Depends on gemm_pkg for state, command and config types.
module gemm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  gemm_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   input  logic [1:0]                  req_command,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [gemm_pkg::IDX_W-1:0]  rsp_out_row,
   output logic [gemm_pkg::IDX_W-1:0]  rsp_out_col,
   output logic                        rsp_last,
   output gemm_pkg::ctrl_cmd_type      cmd
);

   gemm_pkg::state_type         state_ff, state_in;
   logic [gemm_pkg::IDX_W-1:0]  i_ff, i_in;
   logic [gemm_pkg::IDX_W-1:0]  j_ff, j_in;
   logic [gemm_pkg::IDX_W-1:0]  l_ff, l_in;
   logic [gemm_pkg::DIM_W-1:0]  dim_m, dim_n, dim_k;
   logic                        row_end, col_end;

   assign dim_m   = gemm_pkg::clamp_dim(cfg.rows_m);
   assign dim_n   = gemm_pkg::clamp_dim(cfg.cols_n);
   assign dim_k   = gemm_pkg::clamp_dim(cfg.inner_k);
   assign row_end = ({1'b0, i_ff} == dim_m - 4'd1);
   assign col_end = ({1'b0, j_ff} == dim_n - 4'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gemm_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         l_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         l_ff     <= l_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      l_in      = l_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.mul_sel = gemm_pkg::MUL_AB;
      cmd.a_addr  = cfg.trans_a ? gemm_pkg::addr_of(l_ff, i_ff) : gemm_pkg::addr_of(i_ff, l_ff);
      cmd.b_addr  = cfg.trans_b ? gemm_pkg::addr_of(j_ff, l_ff) : gemm_pkg::addr_of(l_ff, j_ff);
      cmd.c_addr  = gemm_pkg::addr_of(i_ff, j_ff);

      case (state_ff)
         gemm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == gemm_pkg::CMD_START) begin
                  if (dim_m != '0 && dim_n != '0) begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = gemm_pkg::ST_CLEAR;
                  end
               end else begin
                  cmd.ld_a = (req_command == gemm_pkg::CMD_LOAD_A);
                  cmd.ld_b = (req_command == gemm_pkg::CMD_LOAD_B);
                  cmd.ld_c = (req_command == gemm_pkg::CMD_LOAD_C);
               end
            end
         end
         gemm_pkg::ST_CLEAR: begin
            cmd.clr_acc = 1'b1;
            l_in        = '0;
            state_in    = (dim_k == '0) ? gemm_pkg::ST_HI : gemm_pkg::ST_READ;
         end
         gemm_pkg::ST_READ: begin
            state_in = gemm_pkg::ST_MUL;
         end
         gemm_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = gemm_pkg::ST_ACC;
         end
         gemm_pkg::ST_ACC: begin
            cmd.acc_en = 1'b1;
            if ({1'b0, l_ff} == dim_k - 4'd1) begin
               state_in = gemm_pkg::ST_HI;
            end else begin
               l_in     = l_ff + 3'd1;
               state_in = gemm_pkg::ST_READ;
            end
         end
         gemm_pkg::ST_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = gemm_pkg::MUL_ALPHA_HI;
            state_in    = gemm_pkg::ST_LO;
         end
         gemm_pkg::ST_LO: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = gemm_pkg::MUL_ALPHA_LO;
            cmd.res_load = 1'b1;
            state_in     = gemm_pkg::ST_CMUL;
         end
         gemm_pkg::ST_CMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = gemm_pkg::MUL_BETA_C;
            cmd.res_add = 1'b1;
            state_in    = gemm_pkg::ST_FIN;
         end
         gemm_pkg::ST_FIN: begin
            cmd.out_load = 1'b1;
            state_in     = gemm_pkg::ST_OUT;
         end
         gemm_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.wb_en = 1'b1;
               if (row_end && col_end) begin
                  state_in = gemm_pkg::ST_IDLE;
               end else begin
                  // advance row first, then column
                  if (row_end) begin
                     i_in = '0;
                     j_in = j_ff + 3'd1;
                  end else begin
                     i_in = i_ff + 3'd1;
                  end
                  state_in = gemm_pkg::ST_CLEAR;
               end
            end
         end
         default: begin
            state_in = gemm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_out_row = i_ff;
   assign rsp_out_col = j_ff;
   assign rsp_last    = row_end && col_end;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("command beat taken while a result beat is pending");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col)))
      else $error("stalled result beat changed");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("block not idle after the last result beat");

endmodule

@@ src/gemm_dp.sv @@
// Datapath: element stores, shared multiplier, dot accumulator and output scaling.
// Depends on gemm_pkg and on gemm_ram for the three element stores.
module gemm_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  gemm_pkg::cfg_type                  cfg,
   input  gemm_pkg::ctrl_cmd_type             cmd,
   input  logic [gemm_pkg::IDX_W-1:0]         ld_row,
   input  logic [gemm_pkg::IDX_W-1:0]         ld_col,
   input  logic signed [gemm_pkg::DATA_W-1:0] ld_value,
   output logic signed [gemm_pkg::DATA_W-1:0] out_value
);

   localparam int PW = gemm_pkg::PROD_W;
   localparam int AW = gemm_pkg::ACC_W;
   localparam int DW = gemm_pkg::DATA_W;
   localparam int MW = gemm_pkg::MUL_W;
   localparam int FW = gemm_pkg::FRAC_W;

   logic [gemm_pkg::ADDR_W-1:0] ld_addr;
   logic                        ld_ok;
   logic [DW-1:0]               a_rdata, b_rdata, c_rdata;
   logic                        c_we;
   logic [gemm_pkg::ADDR_W-1:0] c_waddr;
   logic [DW-1:0]               c_wdata;

   logic signed [MW-1:0] mul_x, mul_y;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW:0]   acc_sum;
   logic signed [PW-1:0] res_ff;
   logic signed [PW-1:0] fin_sum;
   logic signed [DW-1:0] out_ff, sat_val;

   assign ld_addr = gemm_pkg::addr_of(ld_row, ld_col);
   assign ld_ok   = ({1'b0, ld_row} < gemm_pkg::DIM_W'(gemm_pkg::MAX_DIM)) &&
                    ({1'b0, ld_col} < gemm_pkg::DIM_W'(gemm_pkg::MAX_DIM));

   // write back the result into C; loads use the same port while idle
   assign c_we    = (cmd.ld_c && ld_ok) || cmd.wb_en;
   assign c_waddr = cmd.wb_en ? cmd.c_addr : ld_addr;
   assign c_wdata = cmd.wb_en ? out_ff : ld_value;

   gemm_ram #(.WIDTH(DW), .DEPTH(gemm_pkg::DEPTH)) u_store_a (
      .clock (clock),
      .we    (cmd.ld_a && ld_ok),
      .waddr (ld_addr),
      .wdata (ld_value),
      .raddr (cmd.a_addr),
      .rdata (a_rdata)
   );

   gemm_ram #(.WIDTH(DW), .DEPTH(gemm_pkg::DEPTH)) u_store_b (
      .clock (clock),
      .we    (cmd.ld_b && ld_ok),
      .waddr (ld_addr),
      .wdata (ld_value),
      .raddr (cmd.b_addr),
      .rdata (b_rdata)
   );

   gemm_ram #(.WIDTH(DW), .DEPTH(gemm_pkg::DEPTH)) u_store_c (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .raddr (cmd.c_addr),
      .rdata (c_rdata)
   );

   always_comb begin
      case (cmd.mul_sel)
         gemm_pkg::MUL_AB: begin
            mul_x = MW'($signed(a_rdata));
            mul_y = MW'($signed(b_rdata));
         end
         gemm_pkg::MUL_ALPHA_HI: begin
            mul_x = MW'(cfg.alpha_scale);
            mul_y = MW'($signed(acc_ff[AW-1:FW]));
         end
         gemm_pkg::MUL_ALPHA_LO: begin
            mul_x = MW'(cfg.alpha_scale);
            mul_y = $signed({{(MW-FW){1'b0}}, acc_ff[FW-1:0]});
         end
         gemm_pkg::MUL_BETA_C: begin
            // C read data is ignored when beta is zero
            mul_x = MW'(cfg.beta_scale);
            mul_y = (cfg.beta_scale == '0) ? '0 : MW'($signed(c_rdata));
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign prod_in = mul_x * mul_y;
   assign acc_sum = AW'(acc_ff) + $signed(prod_ff[AW+FW-1:FW]);
   assign fin_sum = res_ff + (prod_ff >>> FW);

   always_comb begin
      if (&fin_sum[PW-1:DW-1] || ~|fin_sum[PW-1:DW-1]) begin
         sat_val = fin_sum[DW-1:0];
      end else if (fin_sum[PW-1]) begin
         sat_val = {1'b1, {(DW-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(DW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.clr_acc) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         // saturate at the 48-bit bounds
         if (acc_sum[AW] != acc_sum[AW-1]) begin
            acc_ff <= acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
         end else begin
            acc_ff <= acc_sum[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.res_load) begin
         res_ff <= prod_ff;
      end else if (cmd.res_add) begin
         res_ff <= fin_sum;
      end
      if (cmd.out_load) begin
         out_ff <= sat_val;
      end
   end

   assign out_value = out_ff;

   a_clear_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_acc |=> (acc_ff == '0))
      else $error("dot accumulator not cleared");

endmodule

@@ src/general_matrix_multiply.sv @@
// General matrix multiply, C := alpha*op(A)*op(B) + beta*C in signed Q16.16.
//
// Channels: req_bus carries command beats (load A, load B, load C, start);
// rsp_bus carries result beats (out_row, out_col, out_value, last). The csr_
// port holds trans_a, trans_b, rows_m, cols_n, inner_k, alpha_scale and
// beta_scale at byte addresses 0, 4, ... 24; write it only while idle.
// A load beat writes one store element; indexes at or above MAX_DIM are
// dropped. A start beat walks the result column by column, row inside
// column, and sends one beat per element, last set on the final one; each
// result is also written back into store C. Each element runs a clear
// step, then for each inner step a store read, a multiply and an accumulate
// through the single shared 33x33 multiplier, then the alpha high, alpha
// low, beta times C and finish scaling steps and the output beat. A start
// with m or n zero sends nothing. The block takes no new command beat until
// the last result beat is taken; a stalled receiver holds the result beat.
// Reset is synchronous; it restores the register defaults and returns to
// idle. Store contents are undefined until loaded.
// Depends on gemm_pkg, gemm_if, gemm_csr, gemm_ctrl and gemm_dp.
module general_matrix_multiply (
   input  logic                            clock,
   input  logic                            reset,
   gemm_req_if.sink                        req_bus,
   gemm_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gemm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   gemm_pkg::cfg_type      cfg;
   gemm_pkg::ctrl_cmd_type cmd;

   gemm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gemm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_out_row (rsp_bus.out_row),
      .rsp_out_col (rsp_bus.out_col),
      .rsp_last    (rsp_bus.last),
      .cmd         (cmd)
   );

   gemm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .ld_row    (req_bus.row),
      .ld_col    (req_bus.col),
      .ld_value  (req_bus.value),
      .out_value (rsp_bus.out_value)
   );

endmodule

@@ tb/tb_general_matrix_multiply.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for general_matrix_multiply: a directed table, then random phases.
// Depends on gemm_pkg and the gemm_req_if / gemm_rsp_if channel interfaces.
module tb_general_matrix_multiply;

   localparam int     RANDOM_ITEMS   = 235;
   localparam int     SETTLE_CYCLES  = 3 * gemm_pkg::MAX_DIM + 10;
   localparam int     LONG_HOLD      = 300;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam longint ACC_HI         = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_LO         = -ACC_HI - 1;
   localparam logic signed [95:0] OUT_HI = 96'sd2147483647;
   localparam logic signed [95:0] OUT_LO = -96'sd2147483648;

   typedef struct packed {
      logic [gemm_pkg::IDX_W-1:0]  row;
      logic [gemm_pkg::IDX_W-1:0]  col;
      logic [gemm_pkg::DATA_W-1:0] value;
      logic                        last;
   } result_beat_type;

   typedef struct packed {
      logic                    is_csr;
      gemm_pkg::csr_index_type csr_idx;
      gemm_pkg::cmd_type       command;
      logic [2:0]              row;
      logic [2:0]              col;
      logic [31:0]             value;
      logic                    typed;
      logic [31:0]             typed_value;
   } stim_row_type;

   localparam int N_DIRECTED = 35;

   // Single-element cases are typed in, but the transposed one at the end goes to the predictor.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{1'b1, gemm_pkg::CSR_ROWS_M,  gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_COLS_N,  gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_INNER_K, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'h0001_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'h0002_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0,
        1'b1, 32'h0002_0000},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0,
        1'b1, 32'h7FFF_FFFF},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0,
        1'b1, 32'h8000_0000},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'h8000_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0,
        1'b1, 32'h7FFF_FFFF},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_B, 3'd0, 3'd0, 32'h0000_0001,
        1'b0, 32'h0},
      // tiny negative product rounds down to -1 lsb
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0,
        1'b1, 32'hFFFF_FFFF},
      '{1'b1, gemm_pkg::CSR_BETA,  gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0001_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_C, 3'd0, 3'd0, 32'h0003_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0,
        1'b1, 32'h0002_FFFF},
      // zero inner dimension leaves the C term alone
      '{1'b1, gemm_pkg::CSR_INNER_K, gemm_pkg::CMD_START, 3'd0, 3'd0, 32'd0, 1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0,
        1'b1, 32'h0002_FFFF},
      // zero rows, then zero columns: nothing comes out
      '{1'b1, gemm_pkg::CSR_ROWS_M,  gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd0, 1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE,   gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_ROWS_M,  gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_COLS_N,  gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd0, 1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE,   gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'hFFFF_FFFF,
        1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_COLS_N,  gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_INNER_K, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_TRANS_A, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_TRANS_B, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'd1, 1'b0, 32'h0},
      '{1'b1, gemm_pkg::CSR_ALPHA, gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h8000_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_C, 3'd7, 3'd7, 32'h8000_0000,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE, gemm_pkg::CMD_LOAD_A, 3'd7, 3'd7, 32'h7FFF_FFFF,
        1'b0, 32'h0},
      '{1'b0, gemm_pkg::CSR_SPARE,   gemm_pkg::CMD_START,  3'd0, 3'd0, 32'h0, 1'b0, 32'h0}
   };

   logic clock;
   logic reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [gemm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   gemm_req_if req_bus ();
   gemm_rsp_if rsp_bus ();

   general_matrix_multiply dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state: registers as written and the three element stores.
   gemm_pkg::cfg_type                  shadow_cfg;
   logic signed [gemm_pkg::DATA_W-1:0] mat_a [gemm_pkg::MAX_DIM][gemm_pkg::MAX_DIM];
   logic signed [gemm_pkg::DATA_W-1:0] mat_b [gemm_pkg::MAX_DIM][gemm_pkg::MAX_DIM];
   logic signed [gemm_pkg::DATA_W-1:0] mat_c [gemm_pkg::MAX_DIM][gemm_pkg::MAX_DIM];
   result_beat_type                    pending_elements [$];

   // Which store entries the stimulus has filled, so no start reads an unwritten one.
   bit a_loaded [gemm_pkg::MAX_DIM][gemm_pkg::MAX_DIM];
   bit b_loaded [gemm_pkg::MAX_DIM][gemm_pkg::MAX_DIM];
   bit c_loaded [gemm_pkg::MAX_DIM][gemm_pkg::MAX_DIM];

   int          failures;
   int          random_items;
   int          sender_calm;
   bit          typed_pending;
   logic [31:0] typed_value;
   bit          long_hold_req;
   bit          long_hold_done;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int eff_dim(logic [gemm_pkg::DIM_W-1:0] d);
      return (d > gemm_pkg::MAX_DIM) ? gemm_pkg::MAX_DIM : int'(d);
   endfunction

   function automatic void shadow_csr_write(gemm_pkg::csr_index_type idx, logic [31:0] data);
      case (idx)
         gemm_pkg::CSR_TRANS_A: shadow_cfg.trans_a     = data[0];
         gemm_pkg::CSR_TRANS_B: shadow_cfg.trans_b     = data[0];
         gemm_pkg::CSR_ROWS_M:  shadow_cfg.rows_m      = data[gemm_pkg::DIM_W-1:0];
         gemm_pkg::CSR_COLS_N:  shadow_cfg.cols_n      = data[gemm_pkg::DIM_W-1:0];
         gemm_pkg::CSR_INNER_K: shadow_cfg.inner_k     = data[gemm_pkg::DIM_W-1:0];
         gemm_pkg::CSR_ALPHA:   shadow_cfg.alpha_scale = data;
         gemm_pkg::CSR_BETA:    shadow_cfg.beta_scale  = data;
         default: ;
      endcase
   endfunction

   // Work out every element of alpha*op(A)*op(B) + beta*C, column by column.
   function automatic void predict_product_matrix();
      int                                 m, n, k;
      longint                             prod, acc;
      logic signed [47:0]                 acc48;
      logic signed [gemm_pkg::DATA_W-1:0] av, bv, cv, alpha_q, beta_q, res;
      logic signed [95:0]                 scaled_ab, scaled_c, total;
      result_beat_type                    beat;
      m = eff_dim(shadow_cfg.rows_m);
      n = eff_dim(shadow_cfg.cols_n);
      k = eff_dim(shadow_cfg.inner_k);
      alpha_q = shadow_cfg.alpha_scale;
      beta_q  = shadow_cfg.beta_scale;
      for (int j = 0; j < n; j++) begin
         for (int i = 0; i < m; i++) begin
            acc = 0;
            for (int l = 0; l < k; l++) begin
               av = shadow_cfg.trans_a ? mat_a[l][i] : mat_a[i][l];
               bv = shadow_cfg.trans_b ? mat_b[j][l] : mat_b[l][j];
               prod = longint'(av) * longint'(bv);
               acc = acc + (prod >>> 16);
               if (acc > ACC_HI) acc = ACC_HI;
               if (acc < ACC_LO) acc = ACC_LO;
            end
            acc48 = acc[47:0];
            scaled_ab = alpha_q * acc48;
            total = scaled_ab >>> 16;
            if (beta_q != 0) begin
               cv = mat_c[i][j];
               scaled_c = beta_q * cv;
               total = total + (scaled_c >>> 16);
            end
            if (total > OUT_HI) res = 32'h7FFF_FFFF;
            else if (total < OUT_LO) res = 32'h8000_0000;
            else res = total[gemm_pkg::DATA_W-1:0];
            mat_c[i][j] = res;
            beat.row   = gemm_pkg::IDX_W'(i);
            beat.col   = gemm_pkg::IDX_W'(j);
            beat.value = res;
            beat.last  = (i == m - 1) && (j == n - 1);
            pending_elements.push_back(beat);
         end
      end
   endfunction

   function automatic void apply_command();
      result_beat_type beat;
      case (gemm_pkg::cmd_type'(req_bus.command))
         gemm_pkg::CMD_LOAD_A: mat_a[req_bus.row][req_bus.col] = req_bus.value;
         gemm_pkg::CMD_LOAD_B: mat_b[req_bus.row][req_bus.col] = req_bus.value;
         gemm_pkg::CMD_LOAD_C: mat_c[req_bus.row][req_bus.col] = req_bus.value;
         default: begin
            predict_product_matrix();
            if (typed_pending && pending_elements.size() > 0) begin
               beat = pending_elements.pop_back();
               beat.value = typed_value;
               pending_elements.push_back(beat);
            end
            typed_pending = 1'b0;
         end
      endcase
   endfunction

   function automatic void check_result_beat();
      result_beat_type want;
      if (pending_elements.size() == 0) begin
         $error("result beat row %0d col %0d with no element pending",
                rsp_bus.out_row, rsp_bus.out_col);
         failures++;
      end else begin
         want = pending_elements.pop_front();
         if (rsp_bus.out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, rsp_bus.out_row);
            failures++;
         end
         if (rsp_bus.out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, rsp_bus.out_col);
            failures++;
         end
         if (rsp_bus.out_value !== want.value) begin
            $error("out_value: expected %h, got %h", want.value, rsp_bus.out_value);
            failures++;
         end
         if (rsp_bus.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
            failures++;
         end
      end
   endfunction

   // Check the result beat first: a command taken at the same edge cannot owe it anything.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_result_beat();
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) apply_command();
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Result receiver: short random stalls, a few long ones, calm stretches, one long hold.
   initial begin : result_sink
      int stall;
      int calm;
      int pick;
      stall = 0;
      calm = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !long_hold_done) begin
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
         end
         if (calm > 0) begin
            rsp_bus.ready = 1'b1;
            calm--;
         end else if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) calm = $urandom_range(100, 200);
            else if (pick < 70) rsp_bus.ready = 1'b1;
            else if (pick < 95) stall = $urandom_range(1, 3);
            else stall = $urandom_range(20, 60);
            rsp_bus.ready = (pick < 70);
         end
      end
   end

   function automatic int pick_sender_gap();
      int pick;
      if (sender_calm > 0) begin
         sender_calm--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) sender_calm = $urandom_range(20, 40);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3, 4: return $urandom;
         default: return 32'($urandom_range(0, 20'hF_FFFF)) - 32'h0008_0000;
      endcase
   endfunction

   // Leaves valid high after the beat; the next call lowers it only before a gap, settle_block otherwise.
   task automatic send_item(gemm_pkg::cmd_type command, logic [2:0] row, logic [2:0] col,
                            logic [31:0] value);
      int gap;
      gap = pick_sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         req_bus.value = $urandom;
         repeat (gap) @(negedge clock);
      end
      req_bus.command = command;
      req_bus.row     = row;
      req_bus.col     = col;
      req_bus.value   = value;
      req_bus.valid   = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      case (command)
         gemm_pkg::CMD_LOAD_A: a_loaded[row][col] = 1'b1;
         gemm_pkg::CMD_LOAD_B: b_loaded[row][col] = 1'b1;
         gemm_pkg::CMD_LOAD_C: c_loaded[row][col] = 1'b1;
         default: ;
      endcase
      random_items++;
   endtask

   task automatic send_random_load();
      gemm_pkg::cmd_type command;
      command = gemm_pkg::cmd_type'($urandom_range(0, 2));
      send_item(command, 3'($urandom), 3'($urandom), pick_q16());
   endtask

   // Fill every operand entry the next start will read, then send the start.
   task automatic send_start();
      int m, n, k;
      int r, c;
      m = eff_dim(shadow_cfg.rows_m);
      n = eff_dim(shadow_cfg.cols_n);
      k = eff_dim(shadow_cfg.inner_k);
      if (m > 0 && n > 0) begin
         for (int i = 0; i < m; i++) begin
            for (int l = 0; l < k; l++) begin
               r = shadow_cfg.trans_a ? l : i;
               c = shadow_cfg.trans_a ? i : l;
               if (!a_loaded[r][c]) send_item(gemm_pkg::CMD_LOAD_A, 3'(r), 3'(c), pick_q16());
            end
         end
         for (int j = 0; j < n; j++) begin
            for (int l = 0; l < k; l++) begin
               r = shadow_cfg.trans_b ? j : l;
               c = shadow_cfg.trans_b ? l : j;
               if (!b_loaded[r][c]) send_item(gemm_pkg::CMD_LOAD_B, 3'(r), 3'(c), pick_q16());
            end
         end
         if (shadow_cfg.beta_scale != 0) begin
            for (int i = 0; i < m; i++)
               for (int j = 0; j < n; j++)
                  if (!c_loaded[i][j])
                     send_item(gemm_pkg::CMD_LOAD_C, 3'(i), 3'(j), pick_q16());
         end
      end
      send_item(gemm_pkg::CMD_START, 3'($urandom), 3'($urandom), $urandom);
      for (int i = 0; i < m; i++)
         for (int j = 0; j < n; j++)
            c_loaded[i][j] = 1'b1;
   endtask

   // Drop valid, drain every pending element, then let a trailing load or empty start finish.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(gemm_pkg::csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      shadow_csr_write(idx, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic [31:0] pick_dim();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 32'd0;
      if (pick < 12) return 32'($urandom_range(9, 15));
      if (pick < 20) return 32'd8;
      return 32'($urandom_range(1, 4));
   endfunction

   function automatic logic [31:0] pick_scale(bit allow_zero_often);
      int pick;
      pick = $urandom_range(0, 9);
      if (allow_zero_often && pick < 5) return 32'h0;
      case (pick % 6)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return 32'h0001_0000;
         4: return $urandom;
         default: return 32'($urandom_range(0, 20'h7_FFFF)) - 32'h0004_0000;
      endcase
   endfunction

   task automatic run_random_phase();
      int bursts;
      int loads;
      csr_write(gemm_pkg::CSR_TRANS_A, 32'($urandom_range(0, 1)));
      csr_write(gemm_pkg::CSR_TRANS_B, 32'($urandom_range(0, 1)));
      csr_write(gemm_pkg::CSR_ROWS_M,  pick_dim());
      csr_write(gemm_pkg::CSR_COLS_N,  pick_dim());
      csr_write(gemm_pkg::CSR_INNER_K, pick_dim());
      csr_write(gemm_pkg::CSR_ALPHA,   pick_scale(1'b0));
      csr_write(gemm_pkg::CSR_BETA,    pick_scale(1'b1));
      if ($urandom_range(0, 7) == 0) csr_write(gemm_pkg::CSR_SPARE, $urandom);
      bursts = $urandom_range(1, 3);
      for (int b = 0; b < bursts; b++) begin
         loads = $urandom_range(0, 10);
         repeat (loads) send_random_load();
         send_start();
         // Hold results off once while more commands are offered behind the start.
         if (!long_hold_req && random_items > 40 &&
             eff_dim(shadow_cfg.rows_m) * eff_dim(shadow_cfg.cols_n) >= 4) begin
            long_hold_req = 1'b1;
            repeat (3) send_random_load();
         end
      end
   endtask

   initial begin : stimulus
      bit settled;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = gemm_pkg::CMD_LOAD_A;
      req_bus.row     = '0;
      req_bus.col     = '0;
      req_bus.value   = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      failures        = 0;
      random_items    = 0;
      sender_calm     = 0;
      typed_pending   = 1'b0;
      typed_value     = '0;
      long_hold_req   = 1'b0;
      long_hold_done  = 1'b0;
      shadow_cfg      = '{trans_a: 1'b0, trans_b: 1'b0, rows_m: 4'd8, cols_n: 4'd8,
                          inner_k: 4'd8, alpha_scale: 32'h0001_0000, beta_scale: 32'h0};
      settled = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         if (directed_rows[r].is_csr) begin
            if (!settled) settle_block();
            settled = 1'b1;
            csr_write(directed_rows[r].csr_idx, directed_rows[r].value);
         end else begin
            settled = 1'b0;
            if (directed_rows[r].command == gemm_pkg::CMD_START) begin
               typed_value   = directed_rows[r].typed_value;
               typed_pending = directed_rows[r].typed;
               send_start();
            end else begin
               send_item(directed_rows[r].command, directed_rows[r].row,
                         directed_rows[r].col, directed_rows[r].value);
            end
         end
      end

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle_block();
         run_random_phase();
      end

      settle_block();
      if (failures == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

@@ filelist.f @@
src/gemm_pkg.sv
src/gemm_if.sv
src/gemm_ram.sv
src/gemm_csr.sv
src/gemm_ctrl.sv
src/gemm_dp.sv
src/general_matrix_multiply.sv
tb/tb_general_matrix_multiply.sv
